@@ rtl/core/duplicate_packet_filter_top_defines.svh @@
// assertion macros for the duplicate packet filter checker
// used by dpf_checker, expects clk and rst in the calling scope
`ifndef DUPLICATE_PACKET_FILTER_TOP_DEFINES_SVH
`define DUPLICATE_PACKET_FILTER_TOP_DEFINES_SVH

// checked only outside reset
`define DPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define DPF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/dpf_pkg.sv @@
// shared constants, codes and chain types of the duplicate packet filter
// no dependencies
package dpf_pkg;

  localparam int SEEN_ENTRIES = 32;
  localparam int MAX_LEN      = 64;

  localparam int NUM_CELLS = SEEN_ENTRIES + 1;
  localparam int CELL_W    = $clog2(NUM_CELLS);
  localparam int IDX_W     = $clog2(MAX_LEN);
  localparam int BC_W      = $clog2(MAX_LEN + 1);
  localparam int CNT_W     = $clog2(SEEN_ENTRIES + 1);
  localparam int AGE_W     = (SEEN_ENTRIES > 1) ? $clog2(SEEN_ENTRIES) : 1;
  localparam int HELD_W    = 6;

  localparam int DELEG_LEN = 11;
  localparam int DATA_LEN  = 5;
  localparam int DELEG_IW  = $clog2(DELEG_LEN);
  localparam int DATA_IW   = $clog2(DATA_LEN);

  // "DELEGATION:" and "DATA:"
  localparam logic [7:0] DELEG_PFX [DELEG_LEN] = '{
    8'h44, 8'h45, 8'h4C, 8'h45, 8'h47, 8'h41, 8'h54, 8'h49, 8'h4F, 8'h4E, 8'h3A
  };
  localparam logic [7:0] DATA_PFX [DATA_LEN] = '{8'h44, 8'h41, 8'h54, 8'h41, 8'h3A};

  typedef enum logic [1:0] {
    KIND_UNKNOWN = 2'd0,
    KIND_DATA    = 2'd1,
    KIND_DELEG   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    VERDICT_FORWARD   = 2'd0,
    VERDICT_DUPLICATE = 2'd1,
    VERDICT_UNKNOWN   = 2'd2,
    VERDICT_TOO_LONG  = 2'd3
  } verdict_t;

  // token passed from cell to cell
  typedef struct packed {
    logic             live;
    logic             fin;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
    logic             hit;
  } tok_t;

  // end of packet update, broadcast to all cells
  typedef struct packed {
    logic              commit;
    logic              store;
    logic              full;
    logic [CELL_W-1:0] fill_id;
    logic [BC_W-1:0]   tl;
  } ctl_t;

endpackage

@@ rtl/core/dpf_if.sv @@
// request channel interfaces of the duplicate packet filter
// no dependencies
interface dpf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       has_byte;
  logic       last_byte;

  modport source (output valid, payload_byte, has_byte, last_byte, input ready);
  modport sink (input valid, payload_byte, has_byte, last_byte, output ready);
endinterface

interface dpf_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] packet_kind;
  logic [1:0] verdict;
  logic [5:0] entries_held;

  modport source (output valid, packet_kind, verdict, entries_held, input ready);
  modport sink (input valid, packet_kind, verdict, entries_held, output ready);
endinterface

@@ rtl/core/dpf_cell.sv @@
// one slot of the remembered packet store: text memory, length, age, compare
// depends on dpf_pkg
module dpf_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [dpf_pkg::CELL_W-1:0] cell_id,
  input  dpf_pkg::tok_t             tok_in,
  input  dpf_pkg::ctl_t             ctl,
  output dpf_pkg::tok_t             tok_out
);
  import dpf_pkg::*;

  logic [7:0]       mem [MAX_LEN];
  logic [7:0]       rdata;
  tok_t             tok_q;
  logic             valid;
  logic             staging;
  logic             miss;
  logic [AGE_W-1:0] age;
  logic [IDX_W-1:0] len;
  logic             cmp_miss;

  always_ff @(posedge clk) begin
    if (tok_in.live && staging) begin
      mem[tok_in.idx] <= tok_in.data;
    end
    rdata <= mem[tok_in.idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_in;
    end
  end

  assign cmp_miss = tok_q.live && ((tok_q.idx >= len) || (rdata != tok_q.data));

  always_comb begin
    tok_out     = tok_q;
    tok_out.hit = tok_q.hit | (tok_q.fin && valid && !miss && !cmp_miss &&
                               (BC_W'(len) == ctl.tl));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      staging <= (cell_id == '0);
      miss    <= 1'b0;
    end else if (ctl.commit) begin
      miss <= 1'b0;
      if (ctl.store) begin
        if (staging) begin
          valid   <= 1'b1;
          staging <= 1'b0;
          age     <= '0;
          len     <= ctl.tl[IDX_W-1:0];
        end else if (valid) begin
          if (ctl.full && (age == AGE_W'(SEEN_ENTRIES - 1))) begin
            valid   <= 1'b0;
            staging <= 1'b1;
          end else begin
            age <= age + 1'b1;
          end
        end else if (!ctl.full && (cell_id == ctl.fill_id)) begin
          staging <= 1'b1;
        end
      end
    end else if (tok_q.live) begin
      miss <= miss | cmp_miss;
    end
  end

endmodule

@@ rtl/core/duplicate_packet_filter_top.sv @@
// duplicate packet filter: one request per payload byte, one verdict per packet
// a byte that does not end its packet is taken in one cycle, back to back, while not busy
// the ending request passes a register in each of the SEEN_ENTRIES + 1 slot cells,
// then the pending and output registers; input waits until it leaves the pending one
// synchronous reset empties the store; slot texts need no clearing
// depends on dpf_pkg, dpf_if, dpf_cell
module duplicate_packet_filter_top (
  input logic clk,
  input logic rst,
  dpf_in_if.sink  pkt,
  dpf_out_if.source res
);
  import dpf_pkg::*;

  logic [BC_W-1:0]  byte_count;
  logic [BC_W-1:0]  byte_count_next;
  logic             zero_seen;
  logic             zero_seen_next;
  logic [BC_W-1:0]  tl_cnt;
  logic [BC_W-1:0]  tl_cnt_next;
  logic             deleg_ok;
  logic             deleg_ok_next;
  logic             data_ok;
  logic             data_ok_next;
  logic             busy;
  kind_t            kind_q;
  kind_t            kind_next;
  logic             long_q;
  logic [BC_W-1:0]  tl_q;
  logic [CNT_W-1:0] stored_count;
  logic [CNT_W-1:0] stored_count_next;

  logic             pend_valid;
  kind_t            pend_kind;
  verdict_t         pend_verdict;
  logic [HELD_W-1:0] pend_held;
  logic             out_valid;
  kind_t            out_kind;
  verdict_t         out_verdict;
  logic [HELD_W-1:0] out_held;

  logic             acc;
  logic             take;
  logic             live;
  logic [7:0]       txt;
  logic [IDX_W-1:0] idx;
  logic             done;
  logic             full;
  logic             out_load;
  verdict_t         verdict_now;
  ctl_t             ctl;
  tok_t             tok [NUM_CELLS+1];

  assign pkt.ready = !busy;
  assign acc       = pkt.valid && !busy;

  // byte tracking and prefix check
  always_comb begin
    idx            = byte_count[IDX_W-1:0];
    take           = pkt.has_byte && (byte_count < BC_W'(MAX_LEN));
    zero_seen_next = zero_seen | (pkt.has_byte && (pkt.payload_byte == 8'd0));
    txt            = zero_seen_next ? 8'd0 : pkt.payload_byte;
    live           = take && !zero_seen_next;
    byte_count_next = take ? byte_count + 1'b1 : byte_count;
    tl_cnt_next     = live ? tl_cnt + 1'b1 : tl_cnt;
    deleg_ok_next   = deleg_ok;
    data_ok_next    = data_ok;
    if (take && (byte_count < BC_W'(DELEG_LEN)) && (txt != DELEG_PFX[idx[DELEG_IW-1:0]])) begin
      deleg_ok_next = 1'b0;
    end
    if (take && (byte_count < BC_W'(DATA_LEN)) && (txt != DATA_PFX[idx[DATA_IW-1:0]])) begin
      data_ok_next = 1'b0;
    end
    if (byte_count_next >= BC_W'(MAX_LEN)) begin
      kind_next = KIND_UNKNOWN;
    end else if (deleg_ok_next && (byte_count_next >= BC_W'(DELEG_LEN))) begin
      kind_next = KIND_DELEG;
    end else if (data_ok_next && (byte_count_next >= BC_W'(DATA_LEN))) begin
      kind_next = KIND_DATA;
    end else begin
      kind_next = KIND_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      zero_seen  <= 1'b0;
      tl_cnt     <= '0;
      deleg_ok   <= 1'b1;
      data_ok    <= 1'b1;
    end else if (acc) begin
      if (pkt.last_byte) begin
        byte_count <= '0;
        zero_seen  <= 1'b0;
        tl_cnt     <= '0;
        deleg_ok   <= 1'b1;
        data_ok    <= 1'b1;
      end else begin
        byte_count <= byte_count_next;
        zero_seen  <= zero_seen_next;
        tl_cnt     <= tl_cnt_next;
        deleg_ok   <= deleg_ok_next;
        data_ok    <= data_ok_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && pkt.last_byte) begin
      kind_q <= kind_next;
      long_q <= (byte_count_next >= BC_W'(MAX_LEN));
      tl_q   <= tl_cnt_next;
    end
  end

  // row of slot cells
  always_comb begin
    tok[0]      = '0;
    tok[0].live = acc && live;
    tok[0].fin  = acc && pkt.last_byte;
    tok[0].idx  = idx;
    tok[0].data = txt;
  end

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    dpf_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cell_id (CELL_W'(i)),
      .tok_in  (tok[i]),
      .ctl     (ctl),
      .tok_out (tok[i+1])
    );
  end

  // end of packet decision
  assign done = tok[NUM_CELLS].fin;
  assign full = (stored_count == CNT_W'(SEEN_ENTRIES));

  always_comb begin
    ctl.commit  = done;
    ctl.store   = done && (kind_q != KIND_UNKNOWN) && !tok[NUM_CELLS].hit;
    ctl.full    = full;
    ctl.fill_id = CELL_W'(stored_count + 1'b1);
    ctl.tl      = tl_q;
    stored_count_next = (ctl.store && !full) ? stored_count + 1'b1 : stored_count;
    if (long_q) begin
      verdict_now = VERDICT_TOO_LONG;
    end else if (kind_q == KIND_UNKNOWN) begin
      verdict_now = VERDICT_UNKNOWN;
    end else if (tok[NUM_CELLS].hit) begin
      verdict_now = VERDICT_DUPLICATE;
    end else begin
      verdict_now = VERDICT_FORWARD;
    end
  end

  assign out_load = pend_valid && (!out_valid || res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count <= '0;
      busy         <= 1'b0;
      pend_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      stored_count <= stored_count_next;
      if (acc && pkt.last_byte) begin
        busy <= 1'b1;
      end else if (out_load) begin
        busy <= 1'b0;
      end
      if (done) begin
        pend_valid <= 1'b1;
      end else if (out_load) begin
        pend_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      pend_kind    <= kind_q;
      pend_verdict <= verdict_now;
      pend_held    <= HELD_W'(stored_count_next);
    end
    if (out_load) begin
      out_kind    <= pend_kind;
      out_verdict <= pend_verdict;
      out_held    <= pend_held;
    end
  end

  assign res.valid        = out_valid;
  assign res.packet_kind  = out_kind;
  assign res.verdict      = out_verdict;
  assign res.entries_held = out_held;

endmodule

@@ rtl/core/dpf_checker.sv @@
// port level checks of the duplicate packet filter, bound to its top level
// depends on dpf_pkg and duplicate_packet_filter_top_defines.svh
`include "duplicate_packet_filter_top_defines.svh"

module dpf_checker (
  input logic       clk,
  input logic       rst,
  input logic       pkt_valid,
  input logic       pkt_ready,
  input logic       pkt_last,
  input logic       res_valid,
  input logic       res_ready,
  input logic [1:0] res_kind,
  input logic [1:0] res_verdict,
  input logic [5:0] res_held
);
  import dpf_pkg::*;

  `DPF_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(res_kind) && $stable(res_verdict) && $stable(res_held), "result changed while stalled")
  `DPF_ASSERT(a_busy_after_last, pkt_valid && pkt_ready && pkt_last |=> !pkt_ready, "request taken while a packet is being judged")
  `DPF_ASSERT_ALWAYS(a_kind_verdict, res_valid |-> ((res_kind == KIND_UNKNOWN) == ((res_verdict == VERDICT_UNKNOWN) || (res_verdict == VERDICT_TOO_LONG))), "kind and verdict disagree")

endmodule

bind duplicate_packet_filter_top dpf_checker u_dpf_checker (
  .clk         (clk),
  .rst         (rst),
  .pkt_valid   (pkt.valid),
  .pkt_ready   (pkt.ready),
  .pkt_last    (pkt.last_byte),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .res_kind    (res.packet_kind),
  .res_verdict (res.verdict),
  .res_held    (res.entries_held)
);
